>>> hdl/cpdc_pkg.sv
// ----------------------------------------------------------------------------
// cpdc_pkg: shared types and constants of the cascaded PI converter control
// Field widths, register indexes, fixed buck gains and the configuration
// record handed from the register file to the loop stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cpdc_pkg;

   // field widths
   localparam int VIN_W      = 20;
   localparam int VREF_W     = 19;
   localparam int LIM_W      = 31;
   localparam int CMD_W      = 32;
   localparam int CMP_W      = 12;
   localparam int DUTY_W     = 21;
   localparam int SHIFT_W    = 5;
   localparam int KPV_W      = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VREF      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KI_V      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_KP_V      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_KI_I      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_KP_I      = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_ILIM      = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_VINT_LIM  = CSR_IDX_W'(7);

   // converter modes
   localparam logic MODE_BOOST = 1'b0;
   localparam logic MODE_BUCK  = 1'b1;

   // fixed buck gains
   localparam int BUCK_KI_V_MULT  = 50;
   localparam int BUCK_KI_V_SHIFT = 3;
   localparam int BUCK_KP_V_MULT  = 1280;   // 5 * 256
   localparam int BUCK_KI_I_SHIFT = 18;
   localparam int BUCK_KP_I_SHIFT = 10;

   // compare mapping: 1.17 taken as 1198 / 1024
   localparam int CMP_FACTOR     = 1198;
   localparam int CMP_DUTY_SHIFT = 9;
   localparam int CMP_FRAC       = 10;
   localparam int CMP_MAX        = 4095;

   // register reset values
   localparam logic [SHIFT_W-1:0] KI_V_RESET = SHIFT_W'(8);
   localparam logic [KPV_W-1:0]   KP_V_RESET = KPV_W'(9);
   localparam logic [SHIFT_W-1:0] KI_I_RESET = SHIFT_W'(18);
   localparam logic [SHIFT_W-1:0] KP_I_RESET = SHIFT_W'(11);
   localparam logic [LIM_W-1:0]   LIM_RESET  = LIM_W'(1073741824);

   typedef struct packed {
      logic               mode;
      logic [VREF_W-1:0]  vref;
      logic [SHIFT_W-1:0] ki_v;
      logic [KPV_W-1:0]   kp_v;
      logic [SHIFT_W-1:0] ki_i;
      logic [SHIFT_W-1:0] kp_i;
      logic [LIM_W-1:0]   ilim;
      logic [LIM_W-1:0]   vlim;
   } cfg_type;

   typedef struct packed {
      logic               invert;
      logic [SHIFT_W-1:0] ki_shift;
      logic [SHIFT_W-1:0] kp_shift;
   } phase_gain_type;

endpackage

`default_nettype wire

>>> hdl/cpdc_outer.sv
// ----------------------------------------------------------------------------
// cpdc_outer: outer voltage loop
// Voltage error, clamped integrator and clamped current reference.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdc_outer
   import cpdc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    update,
   input  wire logic signed [VIN_W-1:0] voltage,
   output logic signed [CMD_W-1:0]      iref
);

   localparam int ERR_W  = VIN_W + 1;
   localparam int MUL_W  = ERR_W + 7;
   localparam int SUM_W  = CMD_W + 2;
   localparam int PROP_W = CMD_W + 6;

   logic signed [CMD_W-1:0]  vint_ff;
   logic signed [CMD_W-1:0]  vint_in;

   logic signed [ERR_W-1:0]  vref_s;
   logic signed [ERR_W-1:0]  volt_s;
   logic signed [ERR_W-1:0]  err;
   logic signed [MUL_W-1:0]  err50;
   logic signed [SUM_W-1:0]  inc;
   logic signed [SUM_W-1:0]  vsum;
   logic signed [SUM_W-1:0]  vlim_p;
   logic signed [PROP_W-1:0] prop;
   logic signed [PROP_W-1:0] isum;
   logic signed [PROP_W-1:0] ilim_p;

   always_comb begin
      vref_s = signed'({2'b00, cfg.vref});
      volt_s = ERR_W'(voltage);
      err    = (cfg.mode == MODE_BUCK) ? (volt_s - vref_s) : (vref_s - volt_s);
      err50  = MUL_W'(err) * MUL_W'(BUCK_KI_V_MULT);

      if (cfg.mode == MODE_BUCK) begin
         inc  = SUM_W'(err50 >>> BUCK_KI_V_SHIFT);
         prop = PROP_W'(err) * PROP_W'(BUCK_KP_V_MULT);
      end else begin
         inc  = SUM_W'(err >>> cfg.ki_v);
         prop = PROP_W'(err) <<< cfg.kp_v;
      end

      // integrator clamp
      vlim_p = signed'({3'b000, cfg.vlim});
      vsum   = SUM_W'(vint_ff) + inc;
      if (vsum > vlim_p) begin
         vint_in = CMD_W'(vlim_p);
      end else if (vsum < -vlim_p) begin
         vint_in = CMD_W'(-vlim_p);
      end else begin
         vint_in = CMD_W'(vsum);
      end

      // current reference clamp
      ilim_p = signed'({(PROP_W - LIM_W)'(0), cfg.ilim});
      isum   = PROP_W'(vint_in) + prop;
      if (isum > ilim_p) begin
         iref = CMD_W'(ilim_p);
      end else if (isum < -ilim_p) begin
         iref = CMD_W'(-ilim_p);
      end else begin
         iref = CMD_W'(isum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vint_ff <= '0;
      end else if (update) begin
         vint_ff <= vint_in;
      end
   end

   a_vint_hold: assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(vint_ff))
      else $error("voltage integrator moved without a transaction");

endmodule

`default_nettype wire

>>> hdl/cpdc_phase.sv
// ----------------------------------------------------------------------------
// cpdc_phase: inner current loop of one phase
// Current error, clamped integrator, clamped duty and PWM compare mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdc_phase
   import cpdc_pkg::*;
#(
   parameter int DUTY_MAX   = 1048576,
   parameter int DUTY_MIN   = 0,
   parameter int PWM_PERIOD = 2399
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire phase_gain_type          gain,
   input  wire logic                    update,
   input  wire logic signed [CMD_W-1:0] iref,
   input  wire logic signed [VIN_W-1:0] current,
   output logic [CMP_W-1:0]             compare
);

   localparam int E_W   = CMD_W + 2;
   localparam int E15_W = E_W + 4;
   localparam int SUM_W = E15_W + 2;
   localparam int N_W   = 23;
   localparam int TOT_W = 28;
   localparam int Q_W   = TOT_W - 1 - CMP_FRAC;

   localparam logic signed [SUM_W-1:0] DMAX = SUM_W'(DUTY_MAX);
   localparam logic signed [SUM_W-1:0] DMIN = SUM_W'(DUTY_MIN);
   localparam logic signed [TOT_W-1:0] PERIOD_SCALED = TOT_W'(PWM_PERIOD * 1024);

   logic [DUTY_W-1:0]        pint_ff;
   logic [DUTY_W-1:0]        pint_in;

   logic signed [E_W-1:0]    meas;
   logic signed [E_W-1:0]    ref_e;
   logic signed [E_W-1:0]    e;
   logic signed [E15_W-1:0]  e15;
   logic signed [SUM_W-1:0]  psum;
   logic signed [SUM_W-1:0]  pclamp;
   logic signed [SUM_W-1:0]  dsum;
   logic signed [SUM_W-1:0]  dclamp;
   logic [DUTY_W-1:0]        duty;
   logic [CMP_W-1:0]         duty_hi;
   logic [N_W-1:0]           n;
   logic signed [TOT_W-1:0]  total;
   logic [Q_W-1:0]           q;

   always_comb begin
      meas  = E_W'(current) <<< 10;
      ref_e = E_W'(iref);
      e     = gain.invert ? (meas - ref_e) : (ref_e - meas);
      e15   = (E15_W'(e) <<< 4) - E15_W'(e);

      // integrator clamp, the minimum wins over the maximum
      psum   = SUM_W'(signed'({1'b0, pint_ff})) + SUM_W'(e15 >>> gain.ki_shift);
      pclamp = (psum > DMAX) ? DMAX : psum;
      if (pclamp < DMIN) begin
         pclamp = DMIN;
      end
      pint_in = DUTY_W'(pclamp);

      dsum   = SUM_W'(signed'({1'b0, pint_in})) + SUM_W'(e >>> gain.kp_shift);
      dclamp = (dsum > DMAX) ? DMAX : dsum;
      if (dclamp < DMIN) begin
         dclamp = DMIN;
      end
      duty = DUTY_W'(dclamp);

      // compare = (period*1024 - (duty>>9)*1198) / 1024, saturated
      duty_hi = CMP_W'(duty >> CMP_DUTY_SHIFT);
      n       = N_W'(duty_hi) * N_W'(CMP_FACTOR);
      total   = PERIOD_SCALED - signed'(TOT_W'(n));
      q       = total[TOT_W-2:CMP_FRAC];
      if (total <= 0) begin
         compare = '0;
      end else if (q > Q_W'(CMP_MAX)) begin
         compare = CMP_W'(CMP_MAX);
      end else begin
         compare = q[CMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pint_ff <= '0;
      end else if (update) begin
         pint_ff <= pint_in;
      end
   end

   a_pint_hold: assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(pint_ff))
      else $error("phase integrator moved without a transaction");

   a_pint_floor: assert property (@(posedge clock) disable iff (reset)
      update |=> (pint_ff >= DUTY_W'(DUTY_MIN)))
      else $error("phase integrator below duty minimum after update");

endmodule

`default_nettype wire

>>> hdl/cascaded_pi_dc_converter_control.sv
// ----------------------------------------------------------------------------
// cascaded_pi_dc_converter_control: cascaded PI voltage/current control
// Outer voltage loop feeding three inner phase current loops with PWM
// compare outputs, behind a streaming sample port and a register port.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     req_tdata: voltage, currents a, b, c
//   rsp_     out  rsp_tvalid/tready     rsp_tdata: command, compares a, b, c
//   csr_     in   csr_valid/ready       csr_index, csr_data
//
// one transaction per cycle sustained while rsp_tready stays high; rsp_tvalid
// rises once a sample has passed the input, outer and result registers
// stages: input register, outer loop (voltage integrator), inner loops
// (phase integrators and compare mapping) into the result register
// a stall on rsp_ holds each full stage; req_tready drops once all are full
// reset restores register defaults and clears all integrators at once
// csr_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_pi_dc_converter_control
   import cpdc_pkg::*;
#(
   parameter int DUTY_LIMIT_MAX = 1048576,
   parameter int DUTY_LIMIT_MIN = 0,
   parameter int PWM_PERIOD     = 2399
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [19:0] output_voltage, [39:20] phase_current_a,
   // [59:40] phase_current_b, [79:60] phase_current_c
   input  wire logic [79:0]           req_tdata,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] current_command, [43:32] compare_a, [55:44] compare_b,
   // [67:56] compare_c, [71:68] zero
   output logic [71:0]                rsp_tdata,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NPH = 3;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic signed [VIN_W-1:0] s1_voltage_ff, s1_voltage_in;
   logic signed [VIN_W-1:0] s1_current_ff [NPH];
   logic signed [VIN_W-1:0] s1_current_in [NPH];

   logic                    s2_valid_ff, s2_valid_in;
   logic signed [CMD_W-1:0] s2_iref_ff, s2_iref_in;
   logic signed [VIN_W-1:0] s2_current_ff [NPH];
   logic signed [VIN_W-1:0] s2_current_in [NPH];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CMD_W-1:0] rsp_cmd_ff, rsp_cmd_in;
   logic [CMP_W-1:0]        rsp_cmp_ff [NPH];
   logic [CMP_W-1:0]        rsp_cmp_in [NPH];

   logic [CMP_W-1:0]        cmp [NPH];
   phase_gain_type          gain;

   logic out_open, s2_open, s1_open;
   logic s1_fire, s2_fire, req_fire;

   // register file
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:     cfg_in.mode = csr_data[0];
            CSR_VREF:     cfg_in.vref = csr_data[VREF_W-1:0];
            CSR_KI_V:     cfg_in.ki_v = csr_data[SHIFT_W-1:0];
            CSR_KP_V:     cfg_in.kp_v = csr_data[KPV_W-1:0];
            CSR_KI_I:     cfg_in.ki_i = csr_data[SHIFT_W-1:0];
            CSR_KP_I:     cfg_in.kp_i = csr_data[SHIFT_W-1:0];
            CSR_ILIM:     cfg_in.ilim = csr_data[LIM_W-1:0];
            CSR_VINT_LIM: cfg_in.vlim = csr_data[LIM_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_BOOST;
         cfg_ff.vref <= '0;
         cfg_ff.ki_v <= KI_V_RESET;
         cfg_ff.kp_v <= KP_V_RESET;
         cfg_ff.ki_i <= KI_I_RESET;
         cfg_ff.kp_i <= KP_I_RESET;
         cfg_ff.ilim <= LIM_RESET;
         cfg_ff.vlim <= LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow
   always_comb begin
      out_open   = !rsp_valid_ff || rsp_tready;
      s2_open    = !s2_valid_ff || out_open;
      s1_open    = !s1_valid_ff || s2_open;
      s2_fire    = s2_valid_ff && out_open;
      s1_fire    = s1_valid_ff && s2_open;
      req_tready = s1_open;
      req_fire   = req_tvalid && s1_open;
   end

   cpdc_outer u_outer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .update  (s1_fire),
      .voltage (s1_voltage_ff),
      .iref    (s2_iref_in)
   );

   always_comb begin
      gain.invert   = (cfg_ff.mode == MODE_BUCK);
      gain.ki_shift = (cfg_ff.mode == MODE_BUCK) ? SHIFT_W'(BUCK_KI_I_SHIFT) : cfg_ff.ki_i;
      gain.kp_shift = (cfg_ff.mode == MODE_BUCK) ? SHIFT_W'(BUCK_KP_I_SHIFT) : cfg_ff.kp_i;
   end

   for (genvar k = 0; k < NPH; k++) begin : g_phase
      cpdc_phase #(
         .DUTY_MAX   (DUTY_LIMIT_MAX),
         .DUTY_MIN   (DUTY_LIMIT_MIN),
         .PWM_PERIOD (PWM_PERIOD)
      ) u_phase (
         .clock   (clock),
         .reset   (reset),
         .gain    (gain),
         .update  (s2_fire),
         .iref    (s2_iref_ff),
         .current (s2_current_ff[k]),
         .compare (cmp[k])
      );
   end

   always_comb begin
      s1_valid_in   = s1_open ? req_tvalid : s1_valid_ff;
      s1_voltage_in = req_fire ? signed'(req_tdata[19:0]) : s1_voltage_ff;
      s2_valid_in   = s2_open ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in  = out_open ? s2_valid_ff : rsp_valid_ff;
      rsp_cmd_in    = s2_fire ? s2_iref_ff : rsp_cmd_ff;
      for (int k = 0; k < NPH; k++) begin
         s1_current_in[k] = req_fire ? signed'(req_tdata[VIN_W*(k+1) +: VIN_W])
                                     : s1_current_ff[k];
         s2_current_in[k] = s1_fire ? s1_current_ff[k] : s2_current_ff[k];
         rsp_cmp_in[k]    = s2_fire ? cmp[k] : rsp_cmp_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_voltage_ff <= s1_voltage_in;
      s1_current_ff <= s1_current_in;
      s2_iref_ff    <= s1_fire ? s2_iref_in : s2_iref_ff;
      s2_current_ff <= s2_current_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_cmp_ff    <= rsp_cmp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_cmp_ff[2], rsp_cmp_ff[1], rsp_cmp_ff[0], rsp_cmd_ff};

   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> s2_valid_ff)
      else $error("outer stage transaction lost");

   a_s2_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s2_fire |=> rsp_tvalid)
      else $error("inner stage transaction lost");

endmodule

`default_nettype wire
